>>> hdl/amrq_pkg.sv
// Package for the acked message retry queue: sizes, opcodes, entry and
// controller/datapath command types. No dependencies.
`timescale 1ns / 1ps
package amrq_pkg;
  localparam int DEPTH = 16;
  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [2:0] OP_INSERT  = 3'd0;
  localparam logic [2:0] OP_ACK     = 3'd1;
  localparam logic [2:0] OP_REMOVE  = 3'd2;
  localparam logic [2:0] OP_COMPACT = 3'd3;
  localparam logic [2:0] OP_CLEAR   = 3'd4;
  localparam logic [2:0] OP_TICK    = 3'd5;

  localparam logic [1:0] CFG_ENABLE   = 2'd0;
  localparam logic [1:0] CFG_RETRIES  = 2'd1;
  localparam logic [1:0] CFG_INTERVAL = 2'd2;

  typedef struct packed {
    logic [4:0]  typ;
    logic [1:0]  prio;
    logic        acked;
    logic [7:0]  retries;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [4:0]  alert_type;
    logic [1:0]  priority_req;
    logic [3:0]  index;
    logic [31:0] now;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic        accepted;
    logic [3:0]  slot;
    logic [4:0]  sent_type;
    logic [1:0]  sent_priority;
    logic [31:0] sent_timestamp;
    logic [7:0]  sent_retries;
    logic [4:0]  pending_count;
    logic        last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input item, start
    logic rd;        // read store at scan pointer
    logic step;      // process entry read by the last rd
    logic fin;       // finish op (count update)
    logic mk_status; // build status item
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan;      // op needs a walk
    logic done;      // walk pointer reached end
    logic send;      // step produced a send item
  } dp_sts_t;
endpackage

>>> hdl/amrq_if.sv
// Valid/ready stream interface carrying one payload struct.
// Depends on nothing; payload width given by type parameter.
`timescale 1ns / 1ps
interface amrq_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/amrq_ctrl.sv
// Controller FSM of the retry queue.
// Depends on amrq_pkg command/status types; drives amrq_dp.
`timescale 1ns / 1ps
module amrq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_full,
  output amrq_pkg::dp_cmd_t cmd,
  input  amrq_pkg::dp_sts_t sts
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_RD = 5'b00010, S_STEP = 5'b00100,
    S_FIN = 5'b01000, S_STAT = 5'b10000
  } state_t;
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (!sts.scan || sts.done) state_nxt = S_FIN;
        else begin
          cmd.rd = 1'b1;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        if (!(sts.send && out_full)) begin
          cmd.step = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_FIN: begin
        // insert emits its send request here
        if (!out_full) begin
          cmd.fin = 1'b1;
          state_nxt = S_STAT;
        end
      end
      S_STAT: begin
        if (!out_full) begin
          cmd.mk_status = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == S_IDLE) else $error("ready outside idle");
  a_load_rd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_RD) else $error("load not followed by read");
  a_stat_blk: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mk_status |-> !out_full) else $error("status into full output");
`endif
endmodule

>>> hdl/amrq_dp.sv
// Datapath of the retry queue: entry store, count, walk pointers, output
// register. Uses amrq_pkg types; driven by amrq_ctrl commands.
`timescale 1ns / 1ps
module amrq_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  amrq_pkg::in_item_t  in_data,
  input  amrq_pkg::dp_cmd_t   cmd,
  output amrq_pkg::dp_sts_t   sts,
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_wr_index,
  input  logic [31:0]         cfg_wr_data,
  output logic                out_valid,
  input  logic                out_ready,
  output amrq_pkg::out_item_t out_data
);
  localparam int IW = amrq_pkg::IW;
  localparam int CW = amrq_pkg::CW;

  amrq_pkg::entry_t mem [amrq_pkg::DEPTH];
  amrq_pkg::entry_t rd_r;
  amrq_pkg::in_item_t it_r;
  logic [CW-1:0] count_r, rp_r, wp_r;
  logic acc_r, en_r;
  logic [7:0] maxr_r;
  logic [31:0] ivl_r;
  logic [39:0] lim_r;
  logic ov_r;
  amrq_pkg::out_item_t od_r;
  logic ov_nxt;

  // whether the op needs a walk
  logic scan;
  always_comb begin
    case (it_r.operation)
      amrq_pkg::OP_INSERT, amrq_pkg::OP_REMOVE, amrq_pkg::OP_COMPACT,
      amrq_pkg::OP_TICK: scan = acc_r;
      default: scan = 1'b0;
    endcase
  end

  logic full;
  assign full = (count_r == CW'(amrq_pkg::DEPTH));
  logic [31:0] age;
  assign age = it_r.now - rd_r.stamp;
  logic tick_hit;
  assign tick_hit = !rd_r.acked && (rd_r.retries < maxr_r) && ({8'd0, age} > lim_r);
  logic [CW-1:0] scan_end;
  assign scan_end = (it_r.operation == amrq_pkg::OP_INSERT && !full) ? CW'(0) : count_r;

  assign sts.scan = scan;
  assign sts.done = (rp_r >= scan_end);
  assign sts.send = (it_r.operation == amrq_pkg::OP_TICK) && tick_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= 1'b1;
      maxr_r <= 8'd3;
      ivl_r <= 32'd30000;
    end else if (cfg_wr_en) begin
      case (cfg_wr_index)
        amrq_pkg::CFG_ENABLE:   en_r <= cfg_wr_data[0];
        amrq_pkg::CFG_RETRIES:  maxr_r <= cfg_wr_data[7:0];
        amrq_pkg::CFG_INTERVAL: ivl_r <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  assign ov_nxt = (ov_r && !out_ready) || cmd.mk_status || (cmd.step && sts.send) ||
                  (cmd.fin && acc_r && it_r.operation == amrq_pkg::OP_INSERT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      if (cmd.load) begin
        it_r <= in_data;
        case (in_data.operation)
          amrq_pkg::OP_INSERT: begin
            acc_r <= en_r;
            // full insert: walk shifts from slot 1 as a remove of slot 0
            rp_r <= (en_r && full) ? CW'(1) : CW'(0);
            wp_r <= '0;
          end
          amrq_pkg::OP_ACK: begin
            acc_r <= {1'b0, in_data.index} < count_r;
            rp_r <= '0;
            wp_r <= '0;
            if ({1'b0, in_data.index} < count_r)
              mem[in_data.index[IW-1:0]].acked <= 1'b1;
          end
          amrq_pkg::OP_REMOVE: begin
            acc_r <= {1'b0, in_data.index} < count_r;
            rp_r <= CW'(in_data.index) + CW'(1);
            wp_r <= CW'(in_data.index);
          end
          amrq_pkg::OP_COMPACT, amrq_pkg::OP_CLEAR, amrq_pkg::OP_TICK: begin
            acc_r <= 1'b1;
            rp_r <= '0;
            wp_r <= '0;
          end
          default: begin
            acc_r <= 1'b0;
            rp_r <= '0;
            wp_r <= '0;
          end
        endcase
      end
      if (cmd.rd) begin
        rd_r <= mem[rp_r[IW-1:0]];
      end
      if (cmd.step) begin
        rp_r <= rp_r + CW'(1);
        case (it_r.operation)
          amrq_pkg::OP_TICK: if (tick_hit) begin
            mem[rp_r[IW-1:0]].retries <= rd_r.retries + 8'd1;
            od_r <= '{kind: 1'b1, accepted: 1'b1, slot: 4'(rp_r),
                      sent_type: rd_r.typ, sent_priority: rd_r.prio,
                      sent_timestamp: rd_r.stamp, sent_retries: rd_r.retries + 8'd1,
                      pending_count: 5'(count_r), last: 1'b0};
          end
          amrq_pkg::OP_COMPACT: if (!rd_r.acked) begin
            mem[wp_r[IW-1:0]] <= rd_r;
            wp_r <= wp_r + CW'(1);
          end
          default: begin
            mem[wp_r[IW-1:0]] <= rd_r;
            wp_r <= wp_r + CW'(1);
          end
        endcase
      end
      if (cmd.fin && acc_r) begin
        case (it_r.operation)
          amrq_pkg::OP_INSERT: begin
            if (full) begin
              mem[IW'(amrq_pkg::DEPTH - 1)] <= '{typ: it_r.alert_type,
                  prio: it_r.priority_req, acked: 1'b0, retries: 8'd0, stamp: it_r.now};
              od_r <= '{kind: 1'b1, accepted: 1'b1, slot: 4'(amrq_pkg::DEPTH - 1),
                        sent_type: it_r.alert_type, sent_priority: it_r.priority_req,
                        sent_timestamp: it_r.now, sent_retries: 8'd0,
                        pending_count: 5'(count_r), last: 1'b0};
            end else begin
              mem[count_r[IW-1:0]] <= '{typ: it_r.alert_type,
                  prio: it_r.priority_req, acked: 1'b0, retries: 8'd0, stamp: it_r.now};
              count_r <= count_r + CW'(1);
              od_r <= '{kind: 1'b1, accepted: 1'b1, slot: 4'(count_r),
                        sent_type: it_r.alert_type, sent_priority: it_r.priority_req,
                        sent_timestamp: it_r.now, sent_retries: 8'd0,
                        pending_count: 5'(count_r + CW'(1)), last: 1'b0};
            end
          end
          amrq_pkg::OP_REMOVE: count_r <= count_r - CW'(1);
          amrq_pkg::OP_COMPACT: count_r <= wp_r;
          amrq_pkg::OP_CLEAR: count_r <= '0;
          default: ;
        endcase
      end
      if (cmd.mk_status) begin
        od_r <= '{kind: 1'b0, accepted: acc_r, slot: 4'd0, sent_type: 5'd0,
                  sent_priority: 2'd0, sent_timestamp: 32'd0, sent_retries: 8'd0,
                  pending_count: 5'(count_r), last: 1'b1};
      end
    end
  end

  // threshold product, registered ahead of the compare
  always_ff @(posedge clk) begin
    lim_r <= 40'(ivl_r) * 40'({1'b0, mem[rp_r[IW-1:0]].retries} + 9'd1);
  end

  assign out_valid = ov_r;
  assign out_data = od_r;

`ifndef ASSERT_OFF
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(amrq_pkg::DEPTH)) else $error("count overflow");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ready |=> ov_r && $stable(od_r)) else $error("output lost");
  a_wp: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> wp_r <= rp_r) else $error("write passed read");
`endif
endmodule

>>> hdl/acked_message_retry_queue.sv
// Top level of the acked message retry queue.
// Uses amrq_pkg, amrq_if, amrq_ctrl and amrq_dp.
//
// Usage: one input channel (in_) carries operations; the result channel
// (out_) returns zero or more send requests followed by one status item
// marked last. Configuration (cfg_) is a plain write port; the user is to
// write it only while idle, which the block itself does not enforce.
// Flow: an item is taken only in idle. Without a walk the first result
// is the insert's send request or the status item, and the next item is
// taken only after the status item. Insert into a full table, remove,
// compact and tick walk slots with one store read and one step per slot:
// DEPTH-1 slots for the full insert, the slots above the index for remove,
// every slot below the count for compact and tick.
// Reset clears the count and restores register defaults; store contents
// stay undefined. A stalled receiver holds the output register, and the
// walk waits before each further result until the transfer completes.
`timescale 1ns / 1ps
module acked_message_retry_queue (
  input  logic        clk,
  input  logic        rst_n,
  amrq_if.sink        in_ch,
  amrq_if.source      out_ch,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_index,
  input  logic [31:0] cfg_wr_data
);
  amrq_pkg::dp_cmd_t cmd;
  amrq_pkg::dp_sts_t sts;
  logic out_full;
  assign out_full = out_ch.valid && !out_ch.ready;

  amrq_ctrl u_ctrl (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_full, .cmd, .sts
  );

  amrq_dp u_dp (
    .clk, .rst_n, .in_data(in_ch.data), .cmd, .sts,
    .cfg_wr_en, .cfg_wr_index, .cfg_wr_data,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
  );
endmodule
